@@ rtl/string_frequency_hash_table_unit_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef STRING_FREQUENCY_HASH_TABLE_UNIT_MACROS_SVH
`define STRING_FREQUENCY_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SFH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sfh_pkg.sv @@
`default_nettype none
package sfh_pkg;

  // Table geometry
  localparam int TABLE_SIZE  = 1024;
  localparam int MAX_KEY_LEN = 64;

  // Port field widths
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 32;
  localparam int KLEN_W  = 7;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  // Operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_READ     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_META_RD,
    S_META_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_RD_WAIT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/sfh_rem.sv @@
`default_nettype none
// Home slot of a 32-bit hash: remainder by the table size, registered once.
module sfh_rem (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [31:0]                            dividend,
  output logic                                        done,
  output logic [$clog2(sfh_pkg::TABLE_SIZE)-1:0]      rem
);

  localparam int SW = $clog2(sfh_pkg::TABLE_SIZE);

  // Flag the result in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Table size is a power of two, so the remainder is the low hash bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SW'(dividend % 32'(sfh_pkg::TABLE_SIZE));
    end
  end

endmodule
`default_nettype wire

@@ rtl/string_frequency_hash_table_unit.sv @@
`default_nettype none
// Key-string frequency counter. Key bytes arrive one per transfer (operation 0) with last
// marking the final byte; zero bytes and bytes past MAX_KEY_LEN are ignored. After a byte
// that is not the last the block is ready again. On the last byte the djb2 hash is reduced
// modulo TABLE_SIZE by the registered sfh_rem divider, then the table is probed linearly:
// each probed slot has its metadata read and checked, a length match compares the key byte
// by byte, an insert copies the key byte by byte, and the emit state hands the result to
// the output register. All probing runs through single-read-port memories with registered
// read data, so the block works on one item at a time. After reset a clearing pass over
// all TABLE_SIZE slots empties the table; no item is accepted until it finishes. Counts
// saturate at all ones; a full table drops the key.
module string_frequency_hash_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [7:0]                    key_byte,
  input  wire logic                          last,
  input  wire logic [sfh_pkg::SLOT_W-1:0]    slot_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sfh_pkg::SLOT_W-1:0]         slot,
  output logic [sfh_pkg::COUNT_W-1:0]        hit_count,
  output logic [1:0]                         status,
  output logic [sfh_pkg::KLEN_W-1:0]         key_length
);

  localparam int TABLE_SIZE  = sfh_pkg::TABLE_SIZE;
  localparam int MAX_KEY_LEN = sfh_pkg::MAX_KEY_LEN;
  localparam int SW = $clog2(TABLE_SIZE);
  localparam int PW = SW + 1;
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int BW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int AW = $clog2(TABLE_SIZE * MAX_KEY_LEN);
  localparam int MW = 1 + LW + 32;
  localparam int KS_DEPTH = TABLE_SIZE * MAX_KEY_LEN;

  sfh_pkg::state_t state, state_next;

  // Memories: slot metadata {occupied, length, count}, key store, key buffer
  logic [MW-1:0] meta_mem [TABLE_SIZE];
  logic [7:0]    ks_mem [KS_DEPTH];
  logic [7:0]    kb_mem [MAX_KEY_LEN];

  logic [MW-1:0] meta_q;
  logic [7:0]    ks_q;
  logic [7:0]    kb_q;

  logic          meta_re, meta_we;
  logic [SW-1:0] meta_raddr, meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic          ks_re, ks_we, kb_re, kb_we;
  logic [AW-1:0] ks_addr;

  logic [LW-1:0] key_len;
  logic [31:0]   hash;
  logic [31:0]   hash_next;
  logic [SW-1:0] probe;
  logic [PW-1:0] probes;
  logic [LW-1:0] j;
  logic [SW-1:0] clr;
  logic [sfh_pkg::SLOT_W-1:0] rd_idx;
  logic          rd_ok;
  logic [16:0]   idx_w;

  logic [sfh_pkg::SLOT_W-1:0]  res_slot;
  logic [31:0]                 res_cnt;
  sfh_pkg::status_t            res_st;
  logic [sfh_pkg::KLEN_W-1:0]  res_len;
  sfh_pkg::status_t            out_st;

  logic          in_xfer, out_free, take;
  logic          meta_occ, len_match, probe_wrap, j_last, bytes_match;
  logic [LW-1:0] meta_len;
  logic [31:0]   meta_cnt, cnt_sat;
  logic          miss_adv, hit_done, ins_now;
  logic          div_start, div_done;
  logic [SW-1:0] div_rem;

  sfh_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hash_next),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Decode stored slot and key state, handshake terms and the next hash
  always_comb begin
    in_xfer     = in_valid && in_ready;
    out_free    = !out_valid || out_ready;
    take        = (key_byte != 8'd0) && (key_len < LW'(MAX_KEY_LEN));
    hash_next   = take ? (hash << 5) + hash + 32'(key_byte) : hash;
    idx_w       = 17'(slot_index);
    meta_occ    = meta_q[MW-1];
    meta_len    = meta_q[MW-2:32];
    meta_cnt    = meta_q[31:0];
    cnt_sat     = (meta_cnt == 32'hFFFF_FFFF) ? meta_cnt : meta_cnt + 32'd1;
    len_match   = (meta_len == key_len);
    probe_wrap  = ((probes + PW'(1)) == PW'(TABLE_SIZE));
    j_last      = ((j + LW'(1)) == key_len);
    bytes_match = (kb_q == ks_q);
    ks_addr     = AW'(probe) * AW'(MAX_KEY_LEN) + AW'(j);
    ins_now     = (state == sfh_pkg::S_META_CHK) && !meta_occ;
    miss_adv    = ((state == sfh_pkg::S_META_CHK) && meta_occ && !len_match) ||
                  ((state == sfh_pkg::S_CMP_CHK) && !bytes_match);
    hit_done    = ((state == sfh_pkg::S_META_CHK) && meta_occ && len_match &&
                   (key_len == '0)) ||
                  ((state == sfh_pkg::S_CMP_CHK) && bytes_match && j_last);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sfh_pkg::S_CLEAR: begin
        if (clr == SW'(TABLE_SIZE - 1)) state_next = sfh_pkg::S_IDLE;
      end
      sfh_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (operation == sfh_pkg::OP_READ) state_next = sfh_pkg::S_RD_WAIT;
          else if (last) state_next = sfh_pkg::S_DIV;
        end
      end
      sfh_pkg::S_DIV: begin
        if (div_done) state_next = sfh_pkg::S_META_RD;
      end
      sfh_pkg::S_META_RD: state_next = sfh_pkg::S_META_CHK;
      sfh_pkg::S_META_CHK: begin
        if (!meta_occ) begin
          state_next = (key_len == '0) ? sfh_pkg::S_EMIT : sfh_pkg::S_COPY_RD;
        end else if (len_match) begin
          state_next = (key_len == '0) ? sfh_pkg::S_EMIT : sfh_pkg::S_CMP_RD;
        end else begin
          state_next = probe_wrap ? sfh_pkg::S_EMIT : sfh_pkg::S_META_RD;
        end
      end
      sfh_pkg::S_CMP_RD: state_next = sfh_pkg::S_CMP_CHK;
      sfh_pkg::S_CMP_CHK: begin
        if (!bytes_match) state_next = probe_wrap ? sfh_pkg::S_EMIT : sfh_pkg::S_META_RD;
        else if (j_last) state_next = sfh_pkg::S_EMIT;
        else state_next = sfh_pkg::S_CMP_RD;
      end
      sfh_pkg::S_COPY_RD: state_next = sfh_pkg::S_COPY_WR;
      sfh_pkg::S_COPY_WR: begin
        state_next = j_last ? sfh_pkg::S_EMIT : sfh_pkg::S_COPY_RD;
      end
      sfh_pkg::S_RD_WAIT: state_next = sfh_pkg::S_EMIT;
      sfh_pkg::S_EMIT: begin
        if (out_free) state_next = sfh_pkg::S_IDLE;
      end
      default: state_next = sfh_pkg::S_CLEAR;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    in_ready   = (state == sfh_pkg::S_IDLE);
    div_start  = in_xfer && (operation == sfh_pkg::OP_BYTE) && last;
    meta_re    = (in_xfer && (operation == sfh_pkg::OP_READ)) ||
                 (state == sfh_pkg::S_META_RD);
    meta_raddr = (state == sfh_pkg::S_IDLE) ? idx_w[SW-1:0] : probe;
    meta_we    = (state == sfh_pkg::S_CLEAR) || ins_now || hit_done;
    meta_waddr = (state == sfh_pkg::S_CLEAR) ? clr : probe;
    if (state == sfh_pkg::S_CLEAR) meta_wdata = '0;
    else if (ins_now) meta_wdata = {1'b1, key_len, 32'd1};
    else meta_wdata = {1'b1, meta_len, cnt_sat};
    kb_we      = in_xfer && (operation == sfh_pkg::OP_BYTE) && take;
    kb_re      = (state == sfh_pkg::S_CMP_RD) || (state == sfh_pkg::S_COPY_RD);
    ks_re      = (state == sfh_pkg::S_CMP_RD);
    ks_we      = (state == sfh_pkg::S_COPY_WR);
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (ks_we) ks_mem[ks_addr] <= kb_q;
    if (ks_re) ks_q <= ks_mem[ks_addr];
  end

  always_ff @(posedge clk) begin
    if (kb_we) kb_mem[key_len[BW-1:0]] <= key_byte;
    if (kb_re) kb_q <= kb_mem[j[BW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfh_pkg::S_CLEAR;
      clr       <= '0;
      key_len   <= '0;
      hash      <= sfh_pkg::HASH_SEED;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sfh_pkg::S_CLEAR) clr <= clr + SW'(1);
      if (kb_we) begin
        key_len <= key_len + LW'(1);
        hash    <= hash_next;
      end
      if ((state == sfh_pkg::S_EMIT) && out_free) begin
        out_valid <= 1'b1;
        if (res_st != sfh_pkg::ST_READ) begin
          key_len <= '0;
          hash    <= sfh_pkg::HASH_SEED;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Probe walk, read latch and result staging
  always_ff @(posedge clk) begin
    if (in_xfer && (operation == sfh_pkg::OP_READ)) begin
      rd_idx <= slot_index;
      rd_ok  <= (idx_w < 17'(TABLE_SIZE));
    end
    if ((state == sfh_pkg::S_DIV) && div_done) begin
      probe  <= div_rem;
      probes <= '0;
    end else if (miss_adv) begin
      probes <= probes + PW'(1);
      probe  <= (probe == SW'(TABLE_SIZE - 1)) ? '0 : probe + SW'(1);
    end
    if (state == sfh_pkg::S_META_CHK) j <= '0;
    else if (((state == sfh_pkg::S_CMP_CHK) && bytes_match) ||
             (state == sfh_pkg::S_COPY_WR)) j <= j + LW'(1);

    if (state == sfh_pkg::S_RD_WAIT) begin
      res_slot <= rd_idx;
      res_st   <= sfh_pkg::ST_READ;
      res_cnt  <= rd_ok ? meta_cnt : 32'd0;
      res_len  <= (rd_ok && meta_occ) ? sfh_pkg::KLEN_W'(meta_len) : '0;
    end else if (ins_now) begin
      res_slot <= sfh_pkg::SLOT_W'(probe);
      res_st   <= sfh_pkg::ST_INSERTED;
      res_cnt  <= 32'd1;
      res_len  <= sfh_pkg::KLEN_W'(key_len);
    end else if (hit_done) begin
      res_slot <= sfh_pkg::SLOT_W'(probe);
      res_st   <= sfh_pkg::ST_FOUND;
      res_cnt  <= cnt_sat;
      res_len  <= sfh_pkg::KLEN_W'(meta_len);
    end else if (miss_adv && probe_wrap) begin
      res_slot <= '0;
      res_st   <= sfh_pkg::ST_FULL;
      res_cnt  <= 32'd0;
      res_len  <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == sfh_pkg::S_EMIT) && out_free) begin
      slot       <= res_slot;
      hit_count  <= res_cnt;
      out_st     <= res_st;
      key_length <= res_len;
    end
  end

  assign status = out_st;

endmodule
`default_nettype wire

@@ rtl/sfh_chk.sv @@
`default_nettype none
`include "string_frequency_hash_table_unit_macros.svh"
module sfh_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        operation,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  slot,
  input wire logic [31:0] hit_count,
  input wire logic [1:0]  status,
  input wire logic [6:0]  key_length
);

  // Hold a stalled result
  `SFH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit_count) && $stable(slot), "stalled result changed")

  // Stop taking input while a key end is probed
  `SFH_ASSERT_NXT(a_key_busy, in_valid && in_ready && (operation == sfh_pkg::OP_BYTE) && last, !in_ready, "input taken during probe")

  `SFH_ASSERT_IMP(a_full_zero, out_valid && (status == sfh_pkg::ST_FULL), (slot == 10'd0) && (hit_count == 32'd0) && (key_length == 7'd0), "dropped result not zero")

  `SFH_ASSERT_IMP(a_ins_one, out_valid && (status == sfh_pkg::ST_INSERTED), hit_count == 32'd1, "insert count not one")

  `SFH_ASSERT_IMP(a_found_cnt, out_valid && (status == sfh_pkg::ST_FOUND), hit_count > 32'd1, "found count too small")

endmodule

bind string_frequency_hash_table_unit sfh_chk u_sfh_chk (.*);
`default_nettype wire

@@ verif/string_frequency_hash_table_unit_tb.sv @@
`timescale 1ns / 1ps
module string_frequency_hash_table_unit_tb;

  localparam int TBL = 1024;
  localparam int KMAX = 64;
  localparam int NUM_ITEMS = 1450;
  localparam int POOL_N = 48;
  localparam int POOL_W = 72;

  typedef struct {
    logic               op;
    logic [7:0]         kbyte;
    logic               lst;
    logic [9:0]         idx;
    bit                 typed;
    logic [9:0]         e_slot;
    logic [31:0]        e_cnt;
    sfh_pkg::status_t   e_st;
    logic [6:0]         e_len;
  } stim_t;

  typedef struct {
    logic [9:0]        slot;
    logic [31:0]       cnt;
    sfh_pkg::status_t  st;
    logic [6:0]        len;
  } tally_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [7:0] key_byte = 8'd0;
  logic last = 1'b0;
  logic [9:0] slot_index = 10'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] slot;
  logic [31:0] hit_count;
  logic [1:0] status;
  logic [6:0] key_length;

  string_frequency_hash_table_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .key_byte(key_byte), .last(last), .slot_index(slot_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot(slot), .hit_count(hit_count), .status(status), .key_length(key_length)
  );

  // shadow copy of the table
  logic [7:0]  tbl_key [TBL][KMAX];
  logic [6:0]  tbl_len [TBL];
  bit          tbl_occ [TBL];
  logic [31:0] tbl_cnt [TBL];
  logic [7:0]  cur_key [KMAX];
  int          cur_len;
  logic [31:0] cur_hash;

  tally_t tally_q[$];
  int errors = 0;
  int accepted = 0;
  bit hold_go = 1'b0;

  logic [7:0] pool_b [POOL_N][POOL_W];
  int         pool_len [POOL_N];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // shadow table update for one accepted transfer
  task automatic count_step(input stim_t it, output bit has, output tally_t r);
    int home;
    int s;
    bit done;
    bit eq;
    has = 1'b0;
    r = '{10'd0, 32'd0, sfh_pkg::ST_FOUND, 7'd0};
    if (it.op == sfh_pkg::OP_READ) begin
      has = 1'b1;
      r.slot = it.idx;
      r.cnt = tbl_cnt[it.idx];
      r.st = sfh_pkg::ST_READ;
      r.len = tbl_occ[it.idx] ? tbl_len[it.idx] : 7'd0;
      return;
    end
    if (it.kbyte != 8'd0 && cur_len < KMAX) begin
      cur_key[cur_len] = it.kbyte;
      cur_len++;
      cur_hash = cur_hash * 33 + it.kbyte;
    end
    if (!it.lst) return;
    has = 1'b1;
    done = 1'b0;
    home = int'(cur_hash % TBL);
    // search for a stored copy of the key
    for (int i = 0; i < TBL && !done; i++) begin
      s = (home + i) % TBL;
      if (tbl_occ[s] && tbl_len[s] == 7'(cur_len)) begin
        eq = 1'b1;
        for (int j = 0; j < cur_len; j++) if (tbl_key[s][j] != cur_key[j]) eq = 1'b0;
        if (eq) begin
          if (tbl_cnt[s] != 32'hFFFF_FFFF) tbl_cnt[s]++;
          r = '{10'(s), tbl_cnt[s], sfh_pkg::ST_FOUND, tbl_len[s]};
          done = 1'b1;
        end
      end
    end
    // otherwise claim the first empty slot
    for (int i = 0; i < TBL && !done; i++) begin
      s = (home + i) % TBL;
      if (!tbl_occ[s]) begin
        tbl_occ[s] = 1'b1;
        tbl_len[s] = 7'(cur_len);
        for (int j = 0; j < cur_len; j++) tbl_key[s][j] = cur_key[j];
        tbl_cnt[s] = 32'd1;
        r = '{10'(s), 32'd1, sfh_pkg::ST_INSERTED, 7'(cur_len)};
        done = 1'b1;
      end
    end
    if (!done) r = '{10'd0, 32'd0, sfh_pkg::ST_FULL, 7'd0};
    cur_len = 0;
    cur_hash = sfh_pkg::HASH_SEED;
  endtask

  // offer one item, hold it until the transfer, then log the expected tally
  task automatic offer(input stim_t it);
    bit has;
    tally_t r;
    if (!in_valid) in_valid <= 1'b1;
    operation <= it.op;
    key_byte <= it.kbyte;
    last <= it.lst;
    slot_index <= it.idx;
    do @(posedge clk); while (!in_ready);
    accepted++;
    count_step(it, has, r);
    if (it.typed) tally_q.push_back('{it.e_slot, it.e_cnt, it.e_st, it.e_len});
    else if (has) tally_q.push_back(r);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic stim_t byte_item(logic [7:0] b, logic l);
    return '{sfh_pkg::OP_BYTE, b, l, 10'($urandom), 1'b0, 10'd0, 32'd0,
             sfh_pkg::ST_FOUND, 7'd0};
  endfunction

  function automatic stim_t read_item(logic [9:0] i);
    return '{sfh_pkg::OP_READ, 8'($urandom), 1'($urandom), i, 1'b0, 10'd0, 32'd0,
             sfh_pkg::ST_FOUND, 7'd0};
  endfunction

  // send one key, with stray zero bytes and interleaved reads
  task automatic send_key(input int p, input bit fresh);
    int n;
    logic [7:0] b;
    n = fresh ? $urandom_range(0, 6) : pool_len[p];
    if (n == 0) begin
      offer(byte_item(8'd0, 1'b1));
      sender_gap();
      return;
    end
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 19) == 0) begin
        offer(byte_item(8'd0, 1'b0));
        sender_gap();
      end
      if ($urandom_range(0, 29) == 0) begin
        offer(read_item(10'($urandom)));
        sender_gap();
      end
      // past the stored prefix, vary the tail so truncated keys merge
      if (fresh || j >= KMAX) b = 8'($urandom_range(1, 255));
      else b = pool_b[p][j];
      offer(byte_item(b, j == n - 1));
      sender_gap();
    end
  endtask

  // directed rows; typed expectations only where obvious
  stim_t dir_tab [21] = '{
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'd0,    1'b1, 10'd0,    32'd0, sfh_pkg::ST_READ,     7'd0},
    '{sfh_pkg::OP_READ, 8'hFF, 1'b1, 10'd1023, 1'b1, 10'd1023, 32'd0, sfh_pkg::ST_READ,     7'd0},
    '{sfh_pkg::OP_BYTE, 8'h00, 1'b1, 10'd0,    1'b1, 10'd261,  32'd1, sfh_pkg::ST_INSERTED, 7'd0},
    '{sfh_pkg::OP_BYTE, 8'h00, 1'b1, 10'd0,    1'b1, 10'd261,  32'd2, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'd261,  1'b1, 10'd261,  32'd2, sfh_pkg::ST_READ,     7'd0},
    '{sfh_pkg::OP_BYTE, 8'h61, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'd5,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h00, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'hFF, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h01, 1'b1, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h61, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'hFF, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h01, 1'b1, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h80, 1'b1, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h80, 1'b1, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h55, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'hAA, 1'b0, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_BYTE, 8'h00, 1'b1, 10'd0,    1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'h2AA,  1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'h155,  1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0},
    '{sfh_pkg::OP_READ, 8'h00, 1'b0, 10'd1023, 1'b0, 10'd0,    32'd0, sfh_pkg::ST_FOUND,    7'd0}
  };

  // stimulus
  initial begin
    int p;
    for (int s = 0; s < TBL; s++) begin
      tbl_occ[s] = 1'b0;
      tbl_cnt[s] = 32'd0;
      tbl_len[s] = 7'd0;
    end
    cur_len = 0;
    cur_hash = sfh_pkg::HASH_SEED;
    // key pool: mostly short keys, a few near or past the length limit
    for (int k = 0; k < POOL_N; k++) begin
      pool_len[k] = (k < 4) ? $urandom_range(60, 70) : $urandom_range(1, 5);
      for (int j = 0; j < POOL_W; j++) pool_b[k][j] = 8'($urandom_range(1, 255));
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      offer(dir_tab[i]);
      sender_gap();
    end
    // drain fully before the random part
    in_valid <= 1'b0;
    wait (tally_q.size() == 0);
    @(posedge clk);

    while (accepted < NUM_ITEMS) begin
      if (!hold_go && accepted > 300) hold_go = 1'b1;
      p = $urandom_range(0, 99);
      if (p < 10) begin
        offer(read_item(10'($urandom)));
        sender_gap();
      end else begin
        send_key($urandom_range(0, POOL_N - 1), p < 25);
      end
    end

    // a known key still counts, then read the top slot
    offer(byte_item(8'h80, 1'b1));
    offer(read_item(10'd1023));
    in_valid <= 1'b0;

    wait (tally_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side back-pressure, with one long hold while the sender keeps going
  initial begin
    int r;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 97) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // compare each result transfer with the oldest expected tally
  always @(posedge clk) begin
    tally_t e;
    if (!rst && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        $error("unexpected result: slot %0d count %0d status %0d", slot, hit_count, status);
        errors++;
      end else begin
        e = tally_q.pop_front();
        if (slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot);
          errors++;
        end
        if (hit_count !== e.cnt) begin
          $error("hit_count: expected %0d, got %0d", e.cnt, hit_count);
          errors++;
        end
        if (status !== 2'(e.st)) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
        if (key_length !== e.len) begin
          $error("key_length: expected %0d, got %0d", e.len, key_length);
          errors++;
        end
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sfh_pkg.sv
rtl/sfh_rem.sv
rtl/string_frequency_hash_table_unit.sv
rtl/sfh_chk.sv
verif/string_frequency_hash_table_unit_tb.sv
